// ===== hdl/oust_pkg.sv =====
// Shared types and constants for the ordered unique set table.
`timescale 1ns / 1ps

package oust_pkg;

  localparam int DEF_SET_SIZE = 16;
  localparam int CAUSE_W      = 7;
  localparam int COUNT_OUT_W  = 5;

  typedef logic [CAUSE_W-1:0]     cause_t;
  typedef logic [COUNT_OUT_W-1:0] count_out_t;

  typedef enum logic [2:0] {
    OP_CLEAR  = 3'd0,
    OP_INSERT = 3'd1,
    OP_REMOVE = 3'd2,
    OP_QUERY  = 3'd3,
    OP_MARK   = 3'd4,
    OP_FINISH = 3'd5
  } op_t;

  typedef struct packed {
    op_t    op;
    cause_t cause;
  } req_t;

  typedef struct packed {
    logic       found;
    logic       changed;
    logic       error;
    count_out_t count;
  } rsp_t;

endpackage

// ===== hdl/oust_entry_ram.sv =====
// Entry storage: one write port and one read port with registered read data.
`timescale 1ns / 1ps

module oust_entry_ram #(
  parameter int DEPTH = oust_pkg::DEF_SET_SIZE,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  oust_pkg::cause_t    wdata,
  input  logic                re,
  input  logic [AW-1:0]       raddr,
  output oust_pkg::cause_t    rdata
);

  oust_pkg::cause_t mem [DEPTH];
  oust_pkg::cause_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/oust_seq.sv =====
// Sequencer that walks the entries one per cycle through a shared comparator.
`timescale 1ns / 1ps

module oust_seq #(
  parameter int SET_SIZE = oust_pkg::DEF_SET_SIZE
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           req_valid,
  output logic           req_ready,
  input  oust_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output oust_pkg::rsp_t rsp
);

  localparam int IW = (SET_SIZE > 1) ? $clog2(SET_SIZE) : 1;
  localparam int CW = $clog2(SET_SIZE + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_COMPACT,
    ST_DONE
  } state_t;

  state_t                state_r, state_nxt;
  oust_pkg::op_t         op_r, op_nxt;
  oust_pkg::cause_t      cause_r, cause_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [CW-1:0]         rd_r, rd_nxt;
  logic [CW-1:0]         wr_r, wr_nxt;
  logic [IW-1:0]         pidx_r, pidx_nxt;
  logic [IW-1:0]         pos_r, pos_nxt;
  logic                  pend_r, pend_nxt;
  logic [SET_SIZE-1:0]   marks_r, marks_nxt;
  logic                  found_r, found_nxt;
  logic                  changed_r, changed_nxt;
  logic                  error_r, error_nxt;

  logic                  ram_we;
  logic [IW-1:0]         ram_waddr;
  oust_pkg::cause_t      ram_wdata;
  logic                  ram_re;
  logic [IW-1:0]         ram_raddr;
  oust_pkg::cause_t      ram_rdata;

  logic                  match;
  logic                  keep;

  oust_entry_ram #(
    .DEPTH (SET_SIZE),
    .AW    (IW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The one comparator: the entry read last cycle against the request cause.
  assign match = pend_r && (ram_rdata == cause_r);

  // During a remove everything but the matched entry survives; during a
  // finish only the marked entries do.
  assign keep = (op_r == oust_pkg::OP_FINISH) ? marks_r[pidx_r] : (pidx_r != pos_r);

  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    cause_nxt   = cause_r;
    count_nxt   = count_r;
    rd_nxt      = rd_r;
    wr_nxt      = wr_r;
    pidx_nxt    = pidx_r;
    pos_nxt     = pos_r;
    pend_nxt    = pend_r;
    marks_nxt   = marks_r;
    found_nxt   = found_r;
    changed_nxt = changed_r;
    error_nxt   = error_r;
    ram_we      = 1'b0;
    ram_waddr   = wr_r[IW-1:0];
    ram_wdata   = ram_rdata;
    ram_re      = 1'b0;
    ram_raddr   = rd_r[IW-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (req_valid) begin
          op_nxt      = req.op;
          cause_nxt   = req.cause;
          rd_nxt      = '0;
          wr_nxt      = '0;
          pend_nxt    = 1'b0;
          found_nxt   = 1'b0;
          changed_nxt = 1'b0;
          error_nxt   = 1'b0;
          unique case (req.op) inside
            oust_pkg::OP_CLEAR: begin
              changed_nxt = (count_r != '0);
              count_nxt   = '0;
              marks_nxt   = '0;
              state_nxt   = ST_DONE;
            end
            oust_pkg::OP_INSERT, oust_pkg::OP_QUERY, oust_pkg::OP_MARK: begin
              state_nxt = ST_SEARCH;
            end
            oust_pkg::OP_REMOVE: begin
              if (count_r == '0) begin
                error_nxt = 1'b1;
                state_nxt = ST_DONE;
              end else begin
                state_nxt = ST_SEARCH;
              end
            end
            oust_pkg::OP_FINISH: begin
              state_nxt = ST_COMPACT;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end

      ST_SEARCH: begin
        if (match) begin
          found_nxt = 1'b1;
          pend_nxt  = 1'b0;
          state_nxt = ST_DONE;
          if (op_r == oust_pkg::OP_MARK) begin
            marks_nxt[pidx_r] = 1'b1;
          end
          if (op_r == oust_pkg::OP_REMOVE) begin
            // Compact from the matched slot upward.
            pos_nxt   = pidx_r;
            rd_nxt    = CW'(pidx_r);
            wr_nxt    = CW'(pidx_r);
            state_nxt = ST_COMPACT;
          end
        end else if (rd_r < count_r) begin
          ram_re   = 1'b1;
          pend_nxt = 1'b1;
          pidx_nxt = rd_r[IW-1:0];
          rd_nxt   = rd_r + CW'(1);
        end else if (pend_r) begin
          pend_nxt = 1'b0;
        end else begin
          state_nxt = ST_DONE;
          if (op_r == oust_pkg::OP_INSERT) begin
            if (count_r >= CW'(SET_SIZE)) begin
              error_nxt = 1'b1;
            end else begin
              ram_we                     = 1'b1;
              ram_waddr                  = count_r[IW-1:0];
              ram_wdata                  = cause_r;
              marks_nxt[count_r[IW-1:0]] = 1'b0;
              count_nxt                  = count_r + CW'(1);
              changed_nxt                = 1'b1;
            end
          end
        end
      end

      ST_COMPACT: begin
        if (pend_r && keep) begin
          ram_we                = 1'b1;
          marks_nxt[wr_r[IW-1:0]] = marks_r[pidx_r];
          wr_nxt                = wr_r + CW'(1);
        end
        if (rd_r < count_r) begin
          ram_re   = 1'b1;
          pend_nxt = 1'b1;
          pidx_nxt = rd_r[IW-1:0];
          rd_nxt   = rd_r + CW'(1);
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            count_nxt = wr_r;
            state_nxt = ST_DONE;
            if (op_r == oust_pkg::OP_FINISH) begin
              changed_nxt = (wr_r != count_r);
              marks_nxt   = '0;
            end else begin
              changed_nxt             = 1'b1;
              marks_nxt[wr_r[IW-1:0]] = 1'b0;
            end
          end
        end
      end

      ST_DONE: begin
        if (rsp_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      marks_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      marks_r <= marks_nxt;
      pend_r  <= pend_nxt;
    end
    op_r      <= op_nxt;
    cause_r   <= cause_nxt;
    rd_r      <= rd_nxt;
    wr_r      <= wr_nxt;
    pidx_r    <= pidx_nxt;
    pos_r     <= pos_nxt;
    found_r   <= found_nxt;
    changed_r <= changed_nxt;
    error_r   <= error_nxt;
  end

  assign req_ready   = (state_r == ST_IDLE);
  assign rsp_valid   = (state_r == ST_DONE);
  assign rsp.found   = found_r;
  assign rsp.changed = changed_r;
  assign rsp.error   = error_r;
  assign rsp.count   = oust_pkg::count_out_t'(count_r);

endmodule

// ===== hdl/ordered_unique_set_table_core.sv =====
// Top level of the ordered unique set table: stream ports and result register.
//
//  Channel | Ports                         | Contents
//  --------+-------------------------------+--------------------------------------
//  input   | in_tvalid in_tready in_tdata  | tuser: operation; tdata: cause
//          | in_tuser                      |
//  result  | out_tvalid out_tready         | tdata: found, changed, error, count
//          | out_tdata                     |
//
// A clear or an unused operation goes straight to the result. Query, insert
// and mark search the current entries; a finish compacts them by their marks;
// a remove is a search followed by compaction from the hit, or an error on an
// empty set. The time taken is set by the entry RAM's single read port, which
// feeds one entry per cycle to the shared comparator during a search.
// Reset empties the set and clears all marks at once; there is no clearing pass.
// A new request is taken only once the previous result has moved into the
// output register, which then holds it until out_tready.
`timescale 1ns / 1ps

module ordered_unique_set_table_core #(
  parameter int SET_SIZE = oust_pkg::DEF_SET_SIZE
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [6:0] cause, [7] zero
  input  logic [2:0] in_tuser,   // [2:0] operation
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [0] found, [1] changed, [2] error, [7:3] count
);

  oust_pkg::req_t req;
  oust_pkg::rsp_t rsp;
  oust_pkg::rsp_t out_rsp_r;
  logic           out_valid_r;
  logic           rsp_valid;
  logic           rsp_ready;

  assign req.op    = oust_pkg::op_t'(in_tuser);
  assign req.cause = in_tdata[oust_pkg::CAUSE_W-1:0];

  // The result register can load when empty or when its result leaves now.
  assign rsp_ready = !out_valid_r || out_tready;

  oust_seq #(
    .SET_SIZE (SET_SIZE)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .req_ready (in_tready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rsp_ready) begin
      out_valid_r <= rsp_valid;
    end
    if (rsp_ready && rsp_valid) begin
      out_rsp_r <= rsp;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_rsp_r.count, out_rsp_r.error, out_rsp_r.changed, out_rsp_r.found};

endmodule
